// ===== hdl/eipl4_pkg.sv =====
// Shared constants and the result record for the Ethernet/IP/L4 header parser.
package eipl4_pkg;

    localparam logic [15:0] TYPE_VLAN = 16'h8100;
    localparam logic [15:0] TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] TYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_UDP = 8'd17;
    localparam logic [7:0]  PROTO_TCP = 8'd6;

    localparam logic [7:0] ETH_HDR   = 8'd14;
    localparam logic [7:0] VLAN_END  = 8'd18;
    localparam logic [7:0] IPV4_MIN  = 8'd20;
    localparam logic [7:0] IPV6_HDR  = 8'd40;
    localparam logic [7:0] UDP_HDR   = 8'd8;
    localparam logic [7:0] TCP_MIN   = 8'd20;
    localparam logic [3:0] MIN_WORDS = 4'd5;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_ETH_SHORT  = 4'd1;
    localparam logic [3:0] ST_VLAN_SHORT = 4'd2;
    localparam logic [3:0] ST_V4_SHORT   = 4'd3;
    localparam logic [3:0] ST_V4_IHL     = 4'd4;
    localparam logic [3:0] ST_V4_OPT     = 4'd5;
    localparam logic [3:0] ST_V4_UDP     = 4'd6;
    localparam logic [3:0] ST_V4_TCP     = 4'd7;
    localparam logic [3:0] ST_V4_DOFF    = 4'd8;
    localparam logic [3:0] ST_V4_TOPT    = 4'd9;
    localparam logic [3:0] ST_V6_SHORT   = 4'd10;
    localparam logic [3:0] ST_V6_UDP     = 4'd11;
    localparam logic [3:0] ST_V6_TCP     = 4'd12;
    localparam logic [3:0] ST_V6_DOFF    = 4'd13;
    localparam logic [3:0] ST_V6_TOPT    = 4'd14;

    localparam int FLAG_VLAN = 0;
    localparam int FLAG_IPV4 = 1;
    localparam int FLAG_IPV6 = 2;
    localparam int FLAG_UDP  = 3;
    localparam int FLAG_TCP  = 4;

    typedef struct packed {
        logic [3:0]  status;
        logic [4:0]  layer_flags;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [15:0] ether_type;
        logic [15:0] vlan_tci;
        logic [7:0]  ip_protocol;
        logic [15:0] l4_sport;
        logic [15:0] l4_dport;
        logic [15:0] frame_length;
        logic [15:0] payload_length;
    } t_result;

endpackage

// ===== hdl/ethernet_ip_l4_header_parser_unit.sv =====
// Top level of the streaming Ethernet/VLAN/IPv4/IPv6/UDP/TCP header parser.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  byte in | in        | i_valid, o_stall           | i_data_byte, i_last
//  summary | out       | o_valid, i_stall           | o_status ... o_payload_length
//
// One byte is taken per cycle, back to back, while o_stall is low. Each byte is first held
// in the input register; from there the capture and summary logic update the frame state
// and, on the last byte, load the result register, from which the summary is offered.
// Reset is synchronous and clears the frame state and both valid flags.
// Input is stalled only when a last byte waits behind a summary that is itself stalled.
module ethernet_ip_l4_header_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_status,
    output logic [4:0]  o_layer_flags,
    output logic [47:0] o_dst_mac,
    output logic [47:0] o_src_mac,
    output logic [15:0] o_ether_type,
    output logic [15:0] o_vlan_tci,
    output logic [7:0]  o_ip_protocol,
    output logic [15:0] o_l4_sport,
    output logic [15:0] o_l4_dport,
    output logic [15:0] o_frame_length,
    output logic [15:0] o_payload_length
);

    // Input register.
    logic       r_s1_valid;
    logic       r_s1_last;
    logic [7:0] r_s1_byte;

    // Frame state.
    logic [15:0] r_bytes_seen, n_bytes_seen;
    logic [47:0] r_held_dst, n_held_dst;
    logic [47:0] r_held_src, n_held_src;
    logic [15:0] r_held_type, n_held_type;
    logic        r_tag_seen, n_tag_seen;
    logic [15:0] r_held_tci, n_held_tci;
    logic [4:0]  r_ip_start, n_ip_start;
    logic [3:0]  r_header_words, n_header_words;
    logic [7:0]  r_held_proto, n_held_proto;
    logic [6:0]  r_l4_start, n_l4_start;
    logic [3:0]  r_tcp_words, n_tcp_words;
    logic [31:0] r_held_ports, n_held_ports;

    // Result register.
    logic                r_out_valid;
    eipl4_pkg::t_result  r_out, n_out;

    logic s1_go;

    assign s1_go   = r_s1_valid && (!r_s1_last || !r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_go;

    // Capture of header fields by byte position.
    always_comb begin
        logic [15:0] p;
        logic [7:0]  b;
        logic [15:0] rel;
        logic [15:0] r4;
        logic        go_l4;

        p   = r_bytes_seen;
        b   = r_s1_byte;
        rel = p - {11'd0, r_ip_start};
        r4  = 16'd0;
        go_l4 = 1'b0;

        n_bytes_seen   = (p == 16'hFFFF) ? p : p + 16'd1;
        n_held_dst     = r_held_dst;
        n_held_src     = r_held_src;
        n_held_type    = r_held_type;
        n_tag_seen     = r_tag_seen;
        n_held_tci     = r_held_tci;
        n_ip_start     = r_ip_start;
        n_header_words = r_header_words;
        n_held_proto   = r_held_proto;
        n_l4_start     = r_l4_start;
        n_tcp_words    = r_tcp_words;
        n_held_ports   = r_held_ports;

        if (p < 16'd6) begin
            n_held_dst = {r_held_dst[39:0], b};
        end else if (p < 16'd12) begin
            n_held_src = {r_held_src[39:0], b};
        end else if (p < 16'd14) begin
            n_held_type = {r_held_type[7:0], b};
            if (p == 16'd13) begin
                n_tag_seen = (n_held_type == eipl4_pkg::TYPE_VLAN);
                n_ip_start = n_tag_seen ? eipl4_pkg::VLAN_END[4:0] : eipl4_pkg::ETH_HDR[4:0];
            end
        end else if (r_tag_seen && p < 16'd16) begin
            n_held_tci = {r_held_tci[7:0], b};
        end else if (r_tag_seen && p < 16'd18) begin
            n_held_type = {r_held_type[7:0], b};
        end else if (p >= {11'd0, r_ip_start}) begin
            if (r_held_type == eipl4_pkg::TYPE_IPV4) begin
                if (rel == 16'd0) begin
                    n_header_words = b[3:0];
                    n_l4_start = {2'd0, r_ip_start} + {1'b0, b[3:0], 2'b00};
                end else if (rel == 16'd9) begin
                    n_held_proto = b;
                end
                go_l4 = (n_header_words >= eipl4_pkg::MIN_WORDS);
            end else if (r_held_type == eipl4_pkg::TYPE_IPV6) begin
                if (rel == 16'd0) begin
                    n_l4_start = {2'd0, r_ip_start} + eipl4_pkg::IPV6_HDR[6:0];
                end else if (rel == 16'd6) begin
                    n_held_proto = b;
                end
                go_l4 = 1'b1;
            end
            if (go_l4 && rel != 16'd0 && p >= {9'd0, n_l4_start} &&
                (n_held_proto == eipl4_pkg::PROTO_UDP ||
                 n_held_proto == eipl4_pkg::PROTO_TCP)) begin
                r4 = p - {9'd0, n_l4_start};
                if (r4 < 16'd4) begin
                    n_held_ports = {r_held_ports[23:0], b};
                end else if (r4 == 16'd12 && n_held_proto == eipl4_pkg::PROTO_TCP) begin
                    n_tcp_words = b[7:4];
                end
            end
        end
    end

    // Frame summary, built from the state as it stands after this byte.
    always_comb begin
        logic [15:0] len;
        logic [7:0]  off;
        logic [4:0]  flags;
        logic [3:0]  st;
        logic [7:0]  ihl_bytes;
        logic [7:0]  tcp_bytes;
        logic        is_v4;
        logic        do_l4;

        len       = n_bytes_seen;
        off       = 8'd0;
        flags     = 5'd0;
        st        = eipl4_pkg::ST_OK;
        ihl_bytes = {2'd0, n_header_words, 2'b00};
        tcp_bytes = {2'd0, n_tcp_words, 2'b00};
        is_v4     = 1'b0;
        do_l4     = 1'b0;
        n_out     = '0;
        n_out.frame_length = len;

        if (len < {8'd0, eipl4_pkg::ETH_HDR}) begin
            st = eipl4_pkg::ST_ETH_SHORT;
        end else begin
            n_out.dst_mac    = n_held_dst;
            n_out.src_mac    = n_held_src;
            n_out.ether_type = n_held_type;
            off = eipl4_pkg::ETH_HDR;
            if (n_tag_seen) begin
                if (len < {8'd0, eipl4_pkg::VLAN_END}) begin
                    st = eipl4_pkg::ST_VLAN_SHORT;
                    n_out.ether_type = eipl4_pkg::TYPE_VLAN;
                end else begin
                    flags[eipl4_pkg::FLAG_VLAN] = 1'b1;
                    n_out.vlan_tci = n_held_tci;
                    off = eipl4_pkg::VLAN_END;
                end
            end
            if (st == eipl4_pkg::ST_OK && n_out.ether_type == eipl4_pkg::TYPE_IPV4) begin
                is_v4 = 1'b1;
                if (len < {8'd0, off + eipl4_pkg::IPV4_MIN}) begin
                    st = eipl4_pkg::ST_V4_SHORT;
                end else begin
                    flags[eipl4_pkg::FLAG_IPV4] = 1'b1;
                    n_out.ip_protocol = n_held_proto;
                    if (n_header_words < eipl4_pkg::MIN_WORDS) begin
                        st = eipl4_pkg::ST_V4_IHL;
                    end else if (len < {8'd0, off + ihl_bytes}) begin
                        st = eipl4_pkg::ST_V4_OPT;
                    end else begin
                        off = off + ihl_bytes;
                        do_l4 = 1'b1;
                    end
                end
            end else if (st == eipl4_pkg::ST_OK &&
                         n_out.ether_type == eipl4_pkg::TYPE_IPV6) begin
                if (len < {8'd0, off + eipl4_pkg::IPV6_HDR}) begin
                    st = eipl4_pkg::ST_V6_SHORT;
                end else begin
                    flags[eipl4_pkg::FLAG_IPV6] = 1'b1;
                    n_out.ip_protocol = n_held_proto;
                    off = off + eipl4_pkg::IPV6_HDR;
                    do_l4 = 1'b1;
                end
            end
            if (do_l4) begin
                if (n_held_proto == eipl4_pkg::PROTO_UDP) begin
                    if (len < {8'd0, off + eipl4_pkg::UDP_HDR}) begin
                        st = is_v4 ? eipl4_pkg::ST_V4_UDP : eipl4_pkg::ST_V6_UDP;
                    end else begin
                        flags[eipl4_pkg::FLAG_UDP] = 1'b1;
                        off = off + eipl4_pkg::UDP_HDR;
                    end
                end else if (n_held_proto == eipl4_pkg::PROTO_TCP) begin
                    if (len < {8'd0, off + eipl4_pkg::TCP_MIN}) begin
                        st = is_v4 ? eipl4_pkg::ST_V4_TCP : eipl4_pkg::ST_V6_TCP;
                    end else begin
                        flags[eipl4_pkg::FLAG_TCP] = 1'b1;
                        if (n_tcp_words < eipl4_pkg::MIN_WORDS) begin
                            st = is_v4 ? eipl4_pkg::ST_V4_DOFF : eipl4_pkg::ST_V6_DOFF;
                        end else if (len < {8'd0, off + tcp_bytes}) begin
                            st = is_v4 ? eipl4_pkg::ST_V4_TOPT : eipl4_pkg::ST_V6_TOPT;
                        end else begin
                            off = off + tcp_bytes;
                        end
                    end
                end
            end
            if (flags[eipl4_pkg::FLAG_UDP] || flags[eipl4_pkg::FLAG_TCP]) begin
                n_out.l4_sport = n_held_ports[31:16];
                n_out.l4_dport = n_held_ports[15:0];
            end
            if (st == eipl4_pkg::ST_OK) begin
                n_out.payload_length = len - {8'd0, off};
            end
        end
        n_out.status      = st;
        n_out.layer_flags = flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_stall) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_s1_byte <= i_data_byte;
            r_s1_last <= i_last;
        end
    end

    // The frame state is cleared on reset and again once the last byte has been used.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (s1_go && r_s1_last)) begin
            r_bytes_seen   <= '0;
            r_held_dst     <= '0;
            r_held_src     <= '0;
            r_held_type    <= '0;
            r_tag_seen     <= 1'b0;
            r_held_tci     <= '0;
            r_ip_start     <= '0;
            r_header_words <= '0;
            r_held_proto   <= '0;
            r_l4_start     <= '0;
            r_tcp_words    <= '0;
            r_held_ports   <= '0;
        end else if (s1_go) begin
            r_bytes_seen   <= n_bytes_seen;
            r_held_dst     <= n_held_dst;
            r_held_src     <= n_held_src;
            r_held_type    <= n_held_type;
            r_tag_seen     <= n_tag_seen;
            r_held_tci     <= n_held_tci;
            r_ip_start     <= n_ip_start;
            r_header_words <= n_header_words;
            r_held_proto   <= n_held_proto;
            r_l4_start     <= n_l4_start;
            r_tcp_words    <= n_tcp_words;
            r_held_ports   <= n_held_ports;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_out <= n_out;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out.status;
    assign o_layer_flags    = r_out.layer_flags;
    assign o_dst_mac        = r_out.dst_mac;
    assign o_src_mac        = r_out.src_mac;
    assign o_ether_type     = r_out.ether_type;
    assign o_vlan_tci       = r_out.vlan_tci;
    assign o_ip_protocol    = r_out.ip_protocol;
    assign o_l4_sport       = r_out.l4_sport;
    assign o_l4_dport       = r_out.l4_dport;
    assign o_frame_length   = r_out.frame_length;
    assign o_payload_length = r_out.payload_length;

    // The frame state starts afresh after every summary.
    a_clear_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_s1_last |=> r_bytes_seen == 16'd0)
        else $error("frame state not cleared after last item");

    // A failed parse never reports a payload.
    a_error_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != eipl4_pkg::ST_OK |-> r_out.payload_length == 16'd0)
        else $error("payload length reported on error");

    // Input only stalls while a last item is held behind a stalled summary.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid && r_s1_last && r_out_valid && i_stall)
        else $error("input stalled without a blocked summary");

    // A new summary is only loaded from a last item.
    a_summary_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && r_s1_last))
        else $error("summary raised without a last item");

endmodule
